// ===== hw/rtl/kdc_pkg.sv =====
// Shared constants and types for the k-mer depth and coverage engine.
// No dependencies.
`default_nettype none
package kdc_pkg;
    localparam int MaxGeneLen = 4096;
    localparam int AddrBits   = 12;
    localparam int DepthBits  = 16;
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_KMER  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [2:0] REG_KLEN = 3'd0;
    localparam logic [2:0] REG_MARG = 3'd1;
    localparam logic [2:0] REG_RMAX = 3'd2;
    localparam logic [2:0] REG_RMIN = 3'd3;
    localparam logic [2:0] REG_THR  = 3'd4;

    typedef struct packed {
        logic clr_start;   // begin: latch gene, start clear sweep
        logic kmer_start;  // load k-mer walk
        logic scan_start;  // load scan
        logic div_start;   // start the divisions
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

// ===== hw/rtl/kmer_depth_coverage_engine.sv =====
// Top level of the k-mer depth and coverage engine: config registers, output register.
// Depends on kdc_pkg, kdc_ctrl, kdc_datapath.
// A begin starts a clear sweep of the depth memory; k-mer and end requests walk the bases
// with a read-modify-write per base on the single-port depth memory, and an end then runs
// the dividers before the result is registered. No new request is taken until the last is through.
// Reset: synchronous, active low; a clear sweep of the whole depth memory precedes requests.
`default_nettype none
module kmer_depth_coverage_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_gene_id,
    input  wire logic [12:0] i_item_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_gene_tag,
    output logic [12:0]      o_cov_bases,
    output logic [12:0]      o_gene_len,
    output logic [27:0]      o_depth_total,
    output logic [14:0]      o_coverage_q8,
    output logic [23:0]      o_mean_depth_q8,
    output logic             o_present,
    output logic             o_clip_flag,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import kdc_pkg::*;
    logic [7:0]  r_klen, r_marg;
    logic [15:0] r_rmax, r_rmin;
    logic [14:0] r_thr;
    t_cmd cmd;
    t_sts sts;
    logic res_load, ctrl_ready;
    logic [15:0] d_tag; logic [12:0] d_cov, d_len; logic [27:0] d_sum;
    logic [14:0] d_cq; logic [23:0] d_mq; logic d_pr, d_cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= 8'd30; r_marg <= 8'd10; r_rmax <= 16'd512;
            r_rmin <= 16'd128; r_thr <= 15'd19200;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KLEN: r_klen <= i_cfg_data[7:0];
                REG_MARG: r_marg <= i_cfg_data[7:0];
                REG_RMAX: r_rmax <= i_cfg_data;
                REG_RMIN: r_rmin <= i_cfg_data;
                REG_THR:  r_thr  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_ready = ctrl_ready && sts.walk_done;

    kdc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid(i_valid && sts.walk_done), .i_op,
        .o_ready(ctrl_ready), .o_cmd(cmd), .i_sts(sts),
        .o_res_load(res_load), .i_res_free(!o_valid || i_ready)
    );

    kdc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_gene_id, .i_item_value,
        .i_k_len(r_klen), .i_edge_margin(r_marg),
        .i_ratio_max_q8(r_rmax), .i_ratio_min_q8(r_rmin),
        .i_threshold_pct_q8(r_thr),
        .o_gene_tag(d_tag), .o_cov_bases(d_cov), .o_gene_len(d_len),
        .o_depth_total(d_sum), .o_coverage_q8(d_cq), .o_mean_depth_q8(d_mq),
        .o_present(d_pr), .o_clip_flag(d_cl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (res_load) o_valid <= 1'b1;
        else if (i_ready) o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            o_gene_tag <= d_tag; o_cov_bases <= d_cov; o_gene_len <= d_len;
            o_depth_total <= d_sum; o_coverage_q8 <= d_cq; o_mean_depth_q8 <= d_mq;
            o_present <= d_pr; o_clip_flag <= d_cl;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/kdc_ctrl.sv =====
// Controller state machine: sequences clear, k-mer walk, scan and division.
// Depends on kdc_pkg.
`default_nettype none
module kdc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_op,
    output logic               o_ready,
    output kdc_pkg::t_cmd      o_cmd,
    input  wire kdc_pkg::t_sts i_sts,
    output logic               o_res_load,
    input  wire logic          i_res_free
);
    import kdc_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DIVW = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    logic [2:0] r_state, n_state;
    logic       r_scan, n_scan;
    logic       acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        o_cmd   = '0;
        o_res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_op)
                        OP_BEGIN: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_WALK;
                            n_scan = 1'b0;
                        end
                        OP_KMER: begin
                            o_cmd.kmer_start = 1'b1;
                            n_state = S_WALK;
                            n_scan = 1'b0;
                        end
                        OP_END: begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_WALK;
                            n_scan = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) n_state = r_scan ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: if (i_sts.div_done) n_state = S_OUT;
            S_OUT: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> r_state == S_OUT) else $error("load outside output state");
    a_div_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == S_DIVW) else $error("division not awaited");
endmodule
`default_nettype wire

// ===== hw/rtl/kdc_datapath.sv =====
// Datapath: depth memory, k-mer walk, clear sweep, gap scan, sums and dividers.
// Depends on kdc_pkg.
`default_nettype none
module kdc_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kdc_pkg::t_cmd i_cmd,
    output kdc_pkg::t_sts      o_sts,
    input  wire logic [15:0]   i_gene_id,
    input  wire logic [12:0]   i_item_value,
    input  wire logic [7:0]    i_k_len,
    input  wire logic [7:0]    i_edge_margin,
    input  wire logic [15:0]   i_ratio_max_q8,
    input  wire logic [15:0]   i_ratio_min_q8,
    input  wire logic [14:0]   i_threshold_pct_q8,
    output logic [15:0]        o_gene_tag,
    output logic [12:0]        o_cov_bases,
    output logic [12:0]        o_gene_len,
    output logic [27:0]        o_depth_total,
    output logic [14:0]        o_coverage_q8,
    output logic [23:0]        o_mean_depth_q8,
    output logic               o_present,
    output logic               o_clip_flag
);
    import kdc_pkg::*;
    localparam logic [DepthBits-1:0] DepthCap = '1;
    localparam int DivBits = 37;
    localparam logic [1:0] MODE_CLR  = 2'd0;
    localparam logic [1:0] MODE_KMER = 2'd1;
    localparam logic [1:0] MODE_SCAN = 2'd2;

    logic [DepthBits-1:0] r_mem [MaxGeneLen];
    logic [DepthBits-1:0] r_rd;
    logic [12:0] r_len, r_gene_len, r_pos, r_end;
    logic [15:0] r_gene;
    logic        r_clip;
    logic [1:0]  r_mode;   // clear, k-mer or scan
    logic        r_phase;  // read then write per base
    logic        r_active;
    logic [DepthBits-1:0] r_prev;
    logic        r_checking;
    logic [28:0] r_sum;
    logic [13:0] r_cov;
    logic [7:0]  r_marg;

    logic        in_range, chk, cut;
    logic [DepthBits+8-1:0] d_sh;
    logic [31:0] pmax, pmin;
    logic [DepthBits-1:0] d_new;
    logic        last;

    assign in_range = (r_pos < r_len);
    assign last     = (r_pos == r_end);
    assign d_sh     = {r_rd, 8'd0};
    assign pmax     = i_ratio_max_q8 * r_prev;
    assign pmin     = i_ratio_min_q8 * r_prev;
    assign chk      = r_checking && (r_rd != '0)
                    && ({1'b0, r_pos} + 14'd1 >= {6'd0, r_marg})
                    && ({1'b0, r_pos} + {6'd0, r_marg} + 14'd1 <= {1'b0, r_len});
    assign cut      = chk && ({8'd0, d_sh} > pmax || {8'd0, d_sh} < pmin);
    assign d_new    = cut ? '0 : r_rd;

    always_ff @(posedge i_clk) begin
        if (r_active && r_phase) begin
            case (r_mode)
                MODE_KMER: if (in_range && r_rd != DepthCap)
                    r_mem[r_pos[AddrBits-1:0]] <= r_rd + 1'b1;
                MODE_SCAN: if (cut) r_mem[r_pos[AddrBits-1:0]] <= '0;
                default: ;
            endcase
        end else if (r_active && r_mode == MODE_CLR) begin
            r_mem[r_pos[AddrBits-1:0]] <= '0;
        end
        r_rd <= r_mem[r_pos[AddrBits-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;   // clear sweep after reset
            r_mode   <= MODE_CLR;
            r_pos    <= '0;
            r_end    <= 13'(MaxGeneLen - 1);
            r_phase  <= 1'b0;
            r_len    <= '0;
            r_gene   <= '0;
            r_clip   <= 1'b0;
            r_gene_len <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_active <= 1'b1; r_mode <= MODE_CLR; r_pos <= '0; r_phase <= 1'b0;
                r_end <= 13'(MaxGeneLen - 1);
                r_gene <= i_gene_id;
                r_gene_len <= (i_item_value > 13'(MaxGeneLen)) ? 13'(MaxGeneLen)
                                                               : i_item_value;
                r_len <= (i_item_value > 13'(MaxGeneLen)) ? 13'(MaxGeneLen)
                                                          : i_item_value;
                r_clip <= 1'b0;
            end else if (i_cmd.kmer_start) begin
                r_mode <= MODE_KMER; r_phase <= 1'b0; r_pos <= i_item_value;
                r_active <= (i_k_len != 8'd0);
                r_end <= i_item_value + 13'(i_k_len) - 13'd1;
                if ({1'b0, i_item_value} + 14'(i_k_len) > {1'b0, r_len})
                    r_clip <= (i_k_len != 8'd0) || r_clip;
            end else if (i_cmd.scan_start) begin
                r_mode <= MODE_SCAN; r_phase <= 1'b0; r_pos <= '0;
                r_active <= (r_len != '0);
                r_end <= r_len - 13'd1;
                r_checking <= 1'b1; r_sum <= '0; r_cov <= '0;
                r_marg <= (i_edge_margin < 8'd2) ? 8'd2 : i_edge_margin;
                r_prev <= '0;
            end else if (r_active) begin
                if (r_mode == MODE_CLR) begin
                    r_pos <= r_pos + 13'd1;
                    if (last) r_active <= 1'b0;
                end else if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    r_pos <= r_pos + 13'd1;
                    if (last || (r_mode == MODE_KMER && !in_range)) r_active <= 1'b0;
                    if (r_mode == MODE_SCAN) begin
                        if (r_rd == '0 || cut) r_checking <= 1'b0;
                        r_prev <= d_new;
                        r_sum  <= r_sum + 29'(d_new);
                        if (d_new != '0) r_cov <= r_cov + 14'd1;
                    end
                end
            end
        end
    end

    assign o_sts.walk_done = !r_active;

    // Restoring dividers, one quotient bit per cycle, both share one count.
    logic [DivBits-1:0] r_qa, r_qb;
    logic [13:0] r_ra, r_rb;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [14:0] ta, tb;
    logic [13:0] dvs;
    assign dvs = {1'b0, r_len};
    assign ta = {r_ra, r_qa[DivBits-1]};
    assign tb = {r_rb, r_qb[DivBits-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= (r_len != '0);
            r_cnt  <= 6'(DivBits);
            r_qa <= 37'(r_cov) * 37'd25600;
            r_qb <= {r_sum, 8'd0};
            r_ra <= '0; r_rb <= '0;
        end else if (r_busy) begin
            if (ta >= {1'b0, dvs}) begin
                r_ra <= 14'(ta - {1'b0, dvs}); r_qa <= {r_qa[DivBits-2:0], 1'b1};
            end else begin
                r_ra <= ta[13:0]; r_qa <= {r_qa[DivBits-2:0], 1'b0};
            end
            if (tb >= {1'b0, dvs}) begin
                r_rb <= 14'(tb - {1'b0, dvs}); r_qb <= {r_qb[DivBits-2:0], 1'b1};
            end else begin
                r_rb <= tb[13:0]; r_qb <= {r_qb[DivBits-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end
    assign o_sts.div_done = !r_busy;

    logic zl;
    assign zl = (r_len == '0);
    assign o_gene_tag      = r_gene;
    assign o_gene_len      = r_gene_len;
    assign o_cov_bases     = r_cov[13] ? 13'h1FFF : r_cov[12:0];
    assign o_depth_total   = r_sum[28] ? 28'hFFFFFFF : r_sum[27:0];
    assign o_coverage_q8   = zl ? '0 : r_qa[14:0];
    assign o_mean_depth_q8 = zl ? '0 : ((r_qb[DivBits-1:24] != '0) ? 24'hFFFFFF
                                                                 : r_qb[23:0]);
    assign o_present       = !zl && (r_qa >= 37'(i_threshold_pct_q8));
    assign o_clip_flag     = r_clip;

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 13'(MaxGeneLen)) else $error("length above maximum");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_active) else $error("division during walk");
    a_cut_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_phase && r_mode == MODE_SCAN && cut) |=> !r_checking)
        else $error("checking continues after cut");
endmodule
`default_nettype wire

// ===== test/tb_kmer_depth_coverage_engine.sv =====
// Testbench for kmer_depth_coverage_engine: directed and random gene sequences,
// checked against a behavioural predictor held in a small scoreboard class.
// Depends on kdc_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_kmer_depth_coverage_engine;
    import kdc_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam int         SETTLE      = 4300;
    localparam int         NUM_ITEMS   = 1150;

    typedef struct packed {
        logic [15:0] gene_tag;
        logic [12:0] cov_bases;
        logic [12:0] gene_len;
        logic [27:0] depth_total;
        logic [14:0] coverage_q8;
        logic [23:0] mean_depth_q8;
        logic        present;
        logic        clip_flag;
    } t_gene_report;

    class coverage_scoreboard;
        int unsigned  depth[MaxGeneLen];
        int unsigned  cur_len, cur_gene, clip_seen;
        int unsigned  klen, margin, rmax, rmin, thr;
        t_gene_report pending_reports[$];
        int           errors;

        function new();
            foreach (depth[i]) depth[i] = 0;
            cur_len = 0; cur_gene = 0; clip_seen = 0;
            klen = 30; margin = 10; rmax = 512; rmin = 128; thr = 19200;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_KLEN: klen   = 32'(data[7:0]);
                REG_MARG: margin = 32'(data[7:0]);
                REG_RMAX: rmax   = 32'(data);
                REG_RMIN: rmin   = 32'(data);
                REG_THR:  thr    = 32'(data[14:0]);
                default: ;
            endcase
        endfunction

        function t_gene_report scan_gene();
            t_gene_report     r;
            int unsigned      m, b;
            bit               chk;
            longint unsigned  d, p, sum, cov, cq, mq;
            m = (margin < 2) ? 2 : margin;
            chk = 1; sum = 0; cov = 0; cq = 0; mq = 0;
            for (b = 0; b < cur_len; b++) begin
                d = 64'(depth[b]);
                if (d == 0) chk = 0;
                if (chk && b + 1 >= m && b + m + 1 <= cur_len) begin
                    p = 64'(depth[b-1]);
                    if (d * 256 > rmax * p || d * 256 < rmin * p) begin
                        d = 0;
                        depth[b] = 0;
                        chk = 0;
                    end
                end
                sum += d;
                if (d != 0) cov++;
            end
            if (cur_len != 0) begin
                cq = (cov * 25600) / cur_len;
                mq = (sum * 256) / cur_len;
            end
            r.gene_tag      = cur_gene[15:0];
            r.cov_bases     = (cov > 13'h1FFF) ? 13'h1FFF : cov[12:0];
            r.gene_len      = cur_len[12:0];
            r.depth_total   = (sum > 28'hFFFFFFF) ? 28'hFFFFFFF : sum[27:0];
            r.coverage_q8   = cq[14:0];
            r.mean_depth_q8 = (mq > 24'hFFFFFF) ? 24'hFFFFFF : mq[23:0];
            r.present       = (cur_len != 0 && cq >= thr);
            r.clip_flag     = clip_seen[0];
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [15:0] gid, logic [12:0] val);
            int unsigned pos;
            case (op)
                OP_BEGIN: begin
                    foreach (depth[i]) depth[i] = 0;
                    cur_len = (val > 13'(MaxGeneLen)) ? 32'(MaxGeneLen) : 32'(val);
                    cur_gene = 32'(gid);
                    clip_seen = 0;
                end
                OP_KMER: begin
                    for (int unsigned k = 0; k < klen; k++) begin
                        pos = 32'(val) + k;
                        if (pos < cur_len && pos < MaxGeneLen) begin
                            if (depth[pos] < 65535) depth[pos]++;
                        end else begin
                            clip_seen = 1;
                        end
                    end
                end
                OP_END: pending_reports.insert(pending_reports.size(), scan_gene());
                default: ;
            endcase
        endfunction

        function void check_report(t_gene_report got);
            t_gene_report exp_r;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: tag %0d", got.gene_tag);
                return;
            end
            exp_r = pending_reports.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch tag %0d/%0d cov %0d/%0d len %0d/%0d sum %0d/%0d",
                              " covq %0d/%0d mean %0d/%0d pres %0b/%0b clip %0b/%0b"},
                             exp_r.gene_tag, got.gene_tag,
                             exp_r.cov_bases, got.cov_bases,
                             exp_r.gene_len, got.gene_len,
                             exp_r.depth_total, got.depth_total,
                             exp_r.coverage_q8, got.coverage_q8,
                             exp_r.mean_depth_q8, got.mean_depth_q8,
                             exp_r.present, got.present,
                             exp_r.clip_flag, got.clip_flag);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [15:0] i_gene_id;
    logic [12:0] i_item_value;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_gene_tag;
    logic [12:0] o_cov_bases;
    logic [12:0] o_gene_len;
    logic [27:0] o_depth_total;
    logic [14:0] o_coverage_q8;
    logic [23:0] o_mean_depth_q8;
    logic        o_present;
    logic        o_clip_flag;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    coverage_scoreboard sb = new();
    int  cycles = 0;
    int  items_sent = 0;
    int  reports_seen = 0;
    bit  hold_done = 0;
    int  stall_left = 0;

    kmer_depth_coverage_engine u_top (.*);

    always #1 i_clk = ~i_clk;

    function automatic bit quiet_stretch();
        return ((cycles / 3000) % 4) == 0;
    endfunction

    function automatic int pick_gap();
        if (quiet_stretch() || $urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_kmer_depth_coverage_engine: FAIL");
            $finish;
        end
    end

    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                sb.check_report({o_gene_tag, o_cov_bases, o_gene_len, o_depth_total,
                                 o_coverage_q8, o_mean_depth_q8, o_present, o_clip_flag});
                reports_seen++;
            end
            if (!hold_done && reports_seen == 12) begin
                hold_done = 1;
                stall_left = 20000;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [15:0] gid, logic [12:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_gene_id    <= gid;
        i_item_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(op, gid, val);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned kl, int unsigned mg, int unsigned rx,
                              int unsigned rn, int unsigned th);
        drain_and_settle();
        write_reg(REG_KLEN, kl[15:0]);
        write_reg(REG_MARG, mg[15:0]);
        write_reg(REG_RMAX, rx[15:0]);
        write_reg(REG_RMIN, rn[15:0]);
        write_reg(REG_THR,  th[15:0]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_gene(int unsigned nk);
        logic [12:0] len;
        logic [12:0] start;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 2)       len = 13'd0;
        else if (r < 4)  len = 13'($urandom_range(1, 4));
        else if (r < 6)  len = 13'($urandom_range(4096, 8191));
        else             len = 13'($urandom_range(10, 300));
        send_request(OP_BEGIN, 16'($urandom_range(0, 65535)), len);
        repeat (nk) begin
            if ($urandom_range(0, 19) == 0) start = 13'($urandom_range(0, 8191));
            else start = 13'($urandom_range(0, (len > 13'd300) ? 32'd300 : 32'(len)));
            send_request(OP_KMER, 16'($urandom_range(0, 65535)), start);
            if ($urandom_range(0, 49) == 0)
                send_request(OP_UNUSED, 16'($urandom_range(0, 65535)),
                             13'($urandom_range(0, 8191)));
        end
        send_request(OP_END, 16'($urandom_range(0, 65535)), 13'($urandom_range(0, 8191)));
        if ($urandom_range(0, 9) == 0)
            send_request(OP_END, 16'($urandom_range(0, 65535)),
                         13'($urandom_range(0, 8191)));
    endtask

    initial begin
        int phase;
        i_rst_n = 1'b0; i_valid = 1'b0; i_op = OP_BEGIN; i_gene_id = '0;
        i_item_value = '0; i_cfg_we = 1'b0; i_cfg_idx = REG_KLEN; i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // end without begin, ignored op, empty gene
        send_request(OP_END, 16'h1234, 13'h1FFF);
        send_request(OP_UNUSED, 16'hFFFF, 13'h1FFF);
        send_request(OP_BEGIN, 16'h0000, 13'd0);
        send_request(OP_KMER, 16'h0000, 13'd0);
        send_request(OP_END, 16'h0000, 13'd0);
        // saturated long gene with clipped k-mers, then a repeated end
        send_request(OP_BEGIN, 16'hFFFF, 13'h1FFF);
        send_request(OP_KMER, 16'h0, 13'd0);
        send_request(OP_KMER, 16'h0, 13'd10);
        send_request(OP_KMER, 16'h0, 13'd4080);
        send_request(OP_KMER, 16'h0, 13'h1FFF);
        send_request(OP_END, 16'h0, 13'd0);
        send_request(OP_END, 16'h0, 13'd0);
        // short gene below the margin
        send_request(OP_BEGIN, 16'hA5A5, 13'd5);
        send_request(OP_KMER, 16'h0, 13'd2);
        send_request(OP_END, 16'h0, 13'd0);
        // zero k-mer length and margin below two
        set_config(0, 0, 65535, 0, 256);
        send_request(OP_BEGIN, 16'h5A5A, 13'd40);
        send_request(OP_KMER, 16'h0, 13'd39);
        send_request(OP_END, 16'h0, 13'd0);
        set_config(3, 1, 300, 200, 25600);
        send_request(OP_BEGIN, 16'h0101, 13'd12);
        for (int s = 0; s < 12; s++) send_request(OP_KMER, 16'h0, s[12:0]);
        send_request(OP_KMER, 16'h0, 13'd4);
        send_request(OP_END, 16'h0, 13'd0);

        phase = 0;
        while (items_sent < NUM_ITEMS) begin
            case (phase % 8)
                0: set_config(30, 10, 512, 128, 19200);
                1: set_config(1, 2, 65535, 0, 256);
                2: set_config(255, 255, 1, 65535, 25600);
                default: set_config($urandom_range(1, 40), $urandom_range(0, 20),
                                    $urandom_range(256, 1024), $urandom_range(0, 256),
                                    $urandom_range(256, 25600));
            endcase
            if (phase % 8 == 2) begin
                repeat (3) if (items_sent < NUM_ITEMS) run_gene($urandom_range(1, 4));
            end else begin
                repeat (12) if (items_sent < NUM_ITEMS) run_gene($urandom_range(2, 20));
            end
            phase++;
        end

        drain_and_settle();
        if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
            $display("tb_kmer_depth_coverage_engine: PASS");
        end else begin
            $display("tb_kmer_depth_coverage_engine: FAIL");
        end
        $finish;
    end
endmodule
